@@ rtl/core/hsfc_pkg.sv @@
// ----------------------------------------------------------------------------
// hsfc_pkg: half/single float converter package
// Shared types and field constants for the binary16/binary32 converter.
// ----------------------------------------------------------------------------
package hsfc_pkg;

   typedef enum logic {
      ACT_HALF_TO_SINGLE = 1'b0,
      ACT_SINGLE_TO_HALF = 1'b1
   } action_type;

   localparam logic [7:0]  SGL_EXP_MAX    = 8'hff;
   localparam logic [7:0]  SGL_EXP_OVF    = 8'd143;  // half exponent 31 and above
   localparam logic [7:0]  SGL_EXP_SUBMAX = 8'd112;  // half exponent 0 and below
   localparam logic [7:0]  SGL_EXP_TINY   = 8'd102;  // below half subnormal range
   localparam logic [7:0]  EXP_BIAS_DIFF  = 8'd112;
   localparam logic [7:0]  SUB_SHIFT_BASE = 8'd126;
   localparam logic [14:0] HALF_INF       = 15'h7c00;
   localparam logic [14:0] HALF_QNAN      = 15'h7e00;
   localparam logic [23:0] ROUND_HALF     = 24'h000fff;

endpackage

@@ rtl/core/hsfc_if.sv @@
// ----------------------------------------------------------------------------
// hsfc_req_if / hsfc_rsp_if: converter channels
// Valid/ready channels carrying requests and converted results.
// ----------------------------------------------------------------------------
interface hsfc_req_if;
   import hsfc_pkg::*;
   logic        valid;
   logic        ready;
   action_type  action;
   logic [31:0] operand_bits;
   modport source (output valid, output action, output operand_bits, input ready);
   modport sink   (input valid, input action, input operand_bits, output ready);
endinterface

interface hsfc_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] result_bits;
   modport source (output valid, output result_bits, input ready);
   modport sink   (input valid, input result_bits, output ready);
endinterface

@@ rtl/core/hsfc_h2s.sv @@
// ----------------------------------------------------------------------------
// hsfc_h2s: half to single
// Exact widening; subnormals normalized by a leading-zero search.
// ----------------------------------------------------------------------------
module hsfc_h2s
   import hsfc_pkg::*;
(
   input  logic [15:0] half_bits,
   output logic [31:0] single_bits
);

   logic       sign;
   logic [4:0] expo;
   logic [9:0] mant;
   logic [3:0] msb_pos;
   logic [3:0] lz;
   logic [9:0] norm_mant;
   logic [7:0] sub_exp;

   assign sign = half_bits[15];
   assign expo = half_bits[14:10];
   assign mant = half_bits[9:0];

   always_comb begin
      msb_pos = 4'd0;
      for (int i = 0; i < 10; i++) begin
         if (mant[i]) begin
            msb_pos = 4'(i);
         end
      end
   end

   assign lz        = 4'd10 - msb_pos;
   assign norm_mant = mant << lz;
   assign sub_exp   = 8'd103 + {4'd0, msb_pos};

   always_comb begin
      if (expo == 5'd0) begin
         if (mant == 10'd0) begin
            single_bits = {sign, 31'd0};
         end else begin
            single_bits = {sign, sub_exp, norm_mant, 13'd0};
         end
      end else if (expo == 5'h1f) begin
         single_bits = {sign, 8'hff, mant, 13'd0};
      end else begin
         single_bits = {sign, {3'd0, expo} + EXP_BIAS_DIFF, mant, 13'd0};
      end
   end

endmodule

@@ rtl/core/hsfc_s2h.sv @@
// ----------------------------------------------------------------------------
// hsfc_s2h: single to half
// Round to nearest even for normals, truncate subnormals, flush tiny values.
// ----------------------------------------------------------------------------
module hsfc_s2h
   import hsfc_pkg::*;
(
   input  logic [31:0] single_bits,
   output logic [15:0] half_bits
);

   logic        sign;
   logic [7:0]  efield;
   logic [22:0] mant;
   logic [7:0]  sub_sh;
   logic [23:0] sub_val;
   logic [4:0]  nexp;
   logic [23:0] rounded;
   logic [4:0]  nexp_up;

   assign sign    = single_bits[31];
   assign efield  = single_bits[30:23];
   assign mant    = single_bits[22:0];
   assign sub_sh  = SUB_SHIFT_BASE - efield;
   assign sub_val = {1'b1, mant} >> sub_sh[4:0];
   assign nexp    = 5'(efield - EXP_BIAS_DIFF);
   assign nexp_up = nexp + 5'd1;
   assign rounded = {1'b0, mant} + ROUND_HALF + {23'd0, mant[13]};

   always_comb begin
      if (efield == SGL_EXP_MAX) begin
         half_bits = {sign, (mant != 23'd0) ? HALF_QNAN : HALF_INF};
      end else if (efield >= SGL_EXP_OVF) begin
         half_bits = {sign, HALF_INF};
      end else if (efield <= SGL_EXP_SUBMAX) begin
         if (efield < SGL_EXP_TINY) begin
            half_bits = {sign, 15'd0};
         end else begin
            half_bits = {sign, 5'd0, sub_val[9:0]};
         end
      end else if (rounded[23]) begin
         half_bits = {sign, nexp_up, 10'd0};
      end else begin
         half_bits = {sign, nexp, rounded[22:13]};
      end
   end

endmodule

@@ rtl/core/half_single_float_converter_core.sv @@
// ----------------------------------------------------------------------------
// half_single_float_converter_core: binary16 <-> binary32 converter
// Input register, conversion logic, result register.
// ----------------------------------------------------------------------------
//   channel   dir  payload                      role
//   req_bus   in   action, operand_bits[31:0]   conversion request
//   rsp_bus   out  result_bits[31:0]            converted pattern
//
// A request passes the input register, then the result register, before
// result valid rises; one item per cycle is sustained while the result is
// taken. Request ready drops only while both registers hold items and the
// result is not taken.
// Reset clears the stage valid bits only; payload registers are not reset.
module half_single_float_converter_core
   import hsfc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   hsfc_req_if.sink     req_bus,
   hsfc_rsp_if.source   rsp_bus
);

   logic        in_vld_ff, in_vld_in;
   action_type  in_act_ff;
   logic [31:0] in_opnd_ff;
   logic        out_vld_ff, out_vld_in;
   logic [31:0] out_res_ff, out_res_in;
   logic        out_load;
   logic        in_load;
   logic [31:0] h2s_res;
   logic [15:0] s2h_res;

   // result register frees when empty or its transfer completes
   assign out_load      = !out_vld_ff || rsp_bus.ready;
   assign in_load       = !in_vld_ff || out_load;
   assign req_bus.ready = in_load;

   assign in_vld_in  = in_load ? req_bus.valid : in_vld_ff;
   assign out_vld_in = out_load ? in_vld_ff : out_vld_ff;

   hsfc_h2s u_h2s (
      .half_bits   (in_opnd_ff[15:0]),
      .single_bits (h2s_res)
   );

   hsfc_s2h u_s2h (
      .single_bits (in_opnd_ff),
      .half_bits   (s2h_res)
   );

   assign out_res_in = (in_act_ff == ACT_SINGLE_TO_HALF) ? {16'd0, s2h_res} : h2s_res;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load && req_bus.valid) begin
         in_act_ff  <= req_bus.action;
         in_opnd_ff <= req_bus.operand_bits;
      end
      if (out_load && in_vld_ff) begin
         out_res_ff <= out_res_in;
      end
   end

   assign rsp_bus.valid       = out_vld_ff;
   assign rsp_bus.result_bits = out_res_ff;

endmodule
